// ----- sv/frwt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frwt_pkg
// Shared constants and types of the fractional rank unit.
// ----------------------------------------------------------------------------
package frwt_pkg;

  localparam int unsigned VALUE_IN_BITS  = 32;
  localparam int unsigned INDEX_BITS     = 6;
  localparam int unsigned RANK_BITS      = 8;
  localparam int unsigned MAX_ITEMS_DEF  = 64;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Per-cycle commands from the sequencer to every cell of the chain
  typedef struct packed {
    logic load;    // write the incoming item into the addressed cell
    logic rotate;  // compare against the passing value, then pass it on
    logic shift;   // move ranks one cell towards the output
  } ctrl_t;

endpackage

// ----- sv/frwt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frwt_in_if / frwt_out_if
// Valid/ready channels for vector elements and for ranks.
// ----------------------------------------------------------------------------
interface frwt_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [frwt_pkg::VALUE_IN_BITS-1:0] value;
  logic                                      last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface frwt_out_if;
  logic                             valid;
  logic                             ready;
  logic [frwt_pkg::INDEX_BITS-1:0]  index;
  logic [frwt_pkg::RANK_BITS-1:0]   rank_x2;
  logic                             final_res;
  logic                             overflow;

  modport source (output valid, output index, output rank_x2, output final_res,
                  output overflow, input ready);
  modport sink (input valid, input index, input rank_x2, input final_res,
                input overflow, output ready);
endinterface

// ----- sv/frwt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frwt_cell
// One element of the ranking chain: holds a stored value, a value passing
// round the ring, and the doubled rank built up from the comparisons.
// ----------------------------------------------------------------------------
module frwt_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned CNT_W      = 7,
  parameter int unsigned STORE_BITS = 32
) (
  input  logic                              clk_i,
  input  frwt_pkg::ctrl_t                   ctrl_i,
  input  logic [CNT_W-1:0]                  count_i,
  input  logic [STORE_BITS-1:0]             value_i,
  input  logic [STORE_BITS-1:0]             circ_next_i,
  input  logic [STORE_BITS-1:0]             circ_head_i,
  input  logic [frwt_pkg::RANK_BITS-1:0]    rank_next_i,
  output logic [STORE_BITS-1:0]             circ_o,
  output logic [frwt_pkg::RANK_BITS-1:0]    rank_o
);

  logic [STORE_BITS-1:0]          val_q;
  logic [STORE_BITS-1:0]          circ_q;
  logic [frwt_pkg::RANK_BITS-1:0] rank_q;
  logic                           sel;
  logic                           next_active;
  logic [frwt_pkg::RANK_BITS-1:0] inc;

  assign sel         = ctrl_i.load && (count_i == CNT_W'(IDX));
  // The ring closes after the last loaded cell: wrap back to cell 0 there
  assign next_active = CNT_W'(IDX + 1) < count_i;

  always_comb begin
    if ($signed(circ_q) < $signed(val_q)) begin
      inc = frwt_pkg::RANK_BITS'(2);
    end else if (circ_q == val_q) begin
      inc = frwt_pkg::RANK_BITS'(1);
    end else begin
      inc = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel) begin
      val_q  <= value_i;
      circ_q <= value_i;
      rank_q <= frwt_pkg::RANK_BITS'(1);
    end else if (ctrl_i.rotate) begin
      circ_q <= next_active ? circ_next_i : circ_head_i;
      rank_q <= rank_q + inc;
    end else if (ctrl_i.shift) begin
      rank_q <= rank_next_i;
    end
  end

  assign circ_o = circ_q;
  assign rank_o = rank_q;

endmodule

// ----- sv/frwt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frwt_ctrl
// Sequencer of the ranking chain: load, rotate for one full turn, emit.
// ----------------------------------------------------------------------------
module frwt_ctrl #(
  parameter int unsigned MAX_ITEMS = frwt_pkg::MAX_ITEMS_DEF,
  parameter int unsigned CNT_W     = $clog2(MAX_ITEMS + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_last_i,
  output logic                            in_ready_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [frwt_pkg::INDEX_BITS-1:0] index_o,
  output logic                            final_o,
  output logic                            overflow_o,
  output frwt_pkg::ctrl_t                 ctrl_o,
  output logic [CNT_W-1:0]                count_o
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_RANK,
    S_EMIT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] step_q;
  logic             ovf_q;
  logic             in_acc;
  logic             out_acc;
  logic             full;

  assign in_ready_o  = (state_q == S_LOAD);
  assign out_valid_o = (state_q == S_EMIT);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;
  assign full        = (count_q == CNT_W'(MAX_ITEMS));

  assign ctrl_o.load   = in_acc && !full;
  assign ctrl_o.rotate = (state_q == S_RANK);
  assign ctrl_o.shift  = out_acc;

  assign count_o    = count_q;
  assign index_o    = frwt_pkg::INDEX_BITS'(step_q);
  assign final_o    = (step_q == count_q - CNT_W'(1));
  assign overflow_o = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      count_q <= '0;
      step_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (full) begin
              ovf_q <= 1'b1;
            end else begin
              count_q <= count_q + CNT_W'(1);
            end
            if (in_last_i) begin
              state_q <= S_RANK;
              step_q  <= '0;
            end
          end
        end
        S_RANK: begin
          // One turn of the ring: every cell sees every loaded value once
          if (step_q == count_q - CNT_W'(1)) begin
            state_q <= S_EMIT;
            step_q  <= '0;
          end else begin
            step_q <= step_q + CNT_W'(1);
          end
        end
        S_EMIT: begin
          if (out_acc) begin
            if (final_o) begin
              state_q <= S_LOAD;
              count_q <= '0;
              ovf_q   <= 1'b0;
              step_q  <= '0;
            end else begin
              step_q <= step_q + CNT_W'(1);
            end
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// ----- sv/fractional_rank_with_ties_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_rank_with_ties_unit
// Fractional ranking of a vector with averaged ties, over a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_i takes one vector element per item; an item with last set ends the
//   vector. Up to MAX_ITEMS elements are kept, further ones are dropped and
//   the overflow bit is set on every result of that vector.
//   After the last item the ring of cells turns once over the n stored
//   elements, each cell comparing its own value with the one passing by.
//   Then out_o gives n items in arrival order: index, twice the averaged
//   rank (2*less + equal + 1), final_res on the last one. Each vector is
//   loaded, then the ring turns, then the ranks are shifted out of cell 0.
//   in_i is not ready while a vector is ranked or emitted.
//   A stalled receiver holds the current result; the chain waits with it.
//   Reset empties the store and returns the unit to loading; the values held
//   in the cells are not cleared.
// ----------------------------------------------------------------------------
module fractional_rank_with_ties_unit #(
  parameter int unsigned MAX_ITEMS  = frwt_pkg::MAX_ITEMS_DEF,
  parameter int unsigned VALUE_BITS = frwt_pkg::VALUE_BITS_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  frwt_in_if.sink    in_i,
  frwt_out_if.source out_o
);

  localparam int unsigned CNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int unsigned STORE_BITS =
    (VALUE_BITS < frwt_pkg::VALUE_IN_BITS) ? VALUE_BITS : frwt_pkg::VALUE_IN_BITS;

  frwt_pkg::ctrl_t                ctrl;
  logic [CNT_W-1:0]               count;
  logic [STORE_BITS-1:0]          circ [MAX_ITEMS];
  logic [frwt_pkg::RANK_BITS-1:0] rank [MAX_ITEMS];

  frwt_ctrl #(
    .MAX_ITEMS (MAX_ITEMS),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .index_o     (out_o.index),
    .final_o     (out_o.final_res),
    .overflow_o  (out_o.overflow),
    .ctrl_o      (ctrl),
    .count_o     (count)
  );

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    localparam int unsigned NXT = (g + 1 == MAX_ITEMS) ? 0 : g + 1;
    // The end cell keeps its own rank when the chain shifts
    localparam int unsigned RNX = (g + 1 == MAX_ITEMS) ? g : g + 1;

    frwt_cell #(
      .IDX        (g),
      .CNT_W      (CNT_W),
      .STORE_BITS (STORE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .count_i     (count),
      .value_i     (in_i.value[STORE_BITS-1:0]),
      .circ_next_i (circ[NXT]),
      .circ_head_i (circ[0]),
      .rank_next_i (rank[RNX]),
      .circ_o      (circ[g]),
      .rank_o      (rank[g])
    );
  end

  assign out_o.rank_x2 = rank[0];

endmodule

// ----- test/tb_fractional_rank_with_ties_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fractional_rank_with_ties_unit
// Self-checking bench for the fractional rank unit.
// Vectors of signed values go in, ended by an item with last set. A ranking
// model in the bench computes each element's doubled averaged rank. Each
// result item is checked in order against that model. The bench covers
// extremes, ties, a full store and dropped items, random vectors and long
// receiver stalls.
// ----------------------------------------------------------------------------
module tb_fractional_rank_with_ties_unit;

  typedef logic signed [frwt_pkg::VALUE_IN_BITS-1:0] elem_t;

  typedef struct packed {
    logic [frwt_pkg::INDEX_BITS-1:0] index;
    logic [frwt_pkg::RANK_BITS-1:0]  rank_x2;
    logic                            final_res;
    logic                            overflow;
  } rank_res_t;

  localparam int unsigned STORE_DEPTH  = frwt_pkg::MAX_ITEMS_DEF;
  localparam elem_t       VALUE_MAX    = 32'sh7FFF_FFFF;
  localparam elem_t       VALUE_MIN    = 32'sh8000_0000;
  localparam int          STALL_LIMIT  = 5000;
  localparam int          DRAIN_CYCLES = 200;

  logic clk_i = 1'b0;
  logic rst_ni;

  frwt_in_if  in_ch ();
  frwt_out_if out_ch ();

  fractional_rank_with_ties_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #4ns clk_i = ~clk_i;

  // Ranking model state: elements of the open vector and its drop flag
  elem_t     held_values[$];
  bit        held_dropped;
  rank_res_t pending_ranks[$];

  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  bit          hold_rx;
  int          mismatches;
  int          stall_cycles;

  function automatic void take_element(elem_t v, logic is_last);
    int        less;
    int        equal;
    int        n;
    rank_res_t r;
    if (held_values.size() < STORE_DEPTH) held_values.push_back(v);
    else held_dropped = 1'b1;
    if (!is_last) return;
    n = held_values.size();
    foreach (held_values[i]) begin
      less  = 0;
      equal = 0;
      foreach (held_values[k]) begin
        if (held_values[k] < held_values[i]) less++;
        else if (held_values[k] == held_values[i]) equal++;
      end
      r.index     = 6'(i);
      r.rank_x2   = 8'(2 * less + equal + 1);
      r.final_res = (i == n - 1);
      r.overflow  = held_dropped;
      pending_ranks.push_back(r);
    end
    held_values.delete();
    held_dropped = 1'b0;
  endfunction

  task automatic check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      mismatches++;
    end
  endtask

  // Model update, result checking and watchdog
  always @(posedge clk_i) begin
    rank_res_t exp;
    bit        moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        take_element(in_ch.value, in_ch.last);
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (pending_ranks.size() == 0) begin
          $error("unexpected result: index %0d rank_x2 %0d", out_ch.index, out_ch.rank_x2);
          mismatches++;
        end else begin
          exp = pending_ranks.pop_front();
          check_field("index", exp.index, out_ch.index);
          check_field("rank_x2", exp.rank_x2, out_ch.rank_x2);
          check_field("final_res", exp.final_res, out_ch.final_res);
          check_field("overflow", exp.overflow, out_ch.overflow);
        end
      end
      if (moved) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles == STALL_LIMIT) begin
        $display("fractional_rank_with_ties_unit: mismatch");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_rx) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  function automatic elem_t random_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) return elem_t'($urandom);
    if (pick < 85) return elem_t'($urandom_range(8)) - 4;
    case ($urandom_range(3))
      0: return VALUE_MIN;
      1: return VALUE_MAX;
      2: return '0;
      default: return -1;
    endcase
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(elem_t v, logic is_last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= is_last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_list(elem_t vals[$]);
    foreach (vals[i]) send_item(vals[i], i == vals.size() - 1);
  endtask

  task automatic send_random_vector(int len);
    for (int i = 0; i < len; i++) send_item(random_value(), i == len - 1);
  endtask

  // Drop valid, then hold until every expected result has come
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_ranks.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed_cases();
    send_list('{VALUE_MAX});
    send_list('{VALUE_MIN});
    send_list('{VALUE_MAX, VALUE_MIN, 0, -1, VALUE_MIN, VALUE_MAX, 0});
    send_list('{5, 5, 5, 5});
    send_list('{4, 3, 2, 1, 0, -1});
    drain_results();
  endtask

  task automatic test_store_full();
    // exactly full, then three past full with the last item dropped
    send_random_vector(STORE_DEPTH);
    send_random_vector(STORE_DEPTH + 3);
    drain_results();
  endtask

  task automatic test_random_vectors(int target);
    int sent;
    int len;
    sent = 0;
    while (sent < target) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 10);
      send_random_vector(len);
      sent += len;
      if ($urandom_range(7) == 0) drain_results();
    end
    drain_results();
  endtask

  task automatic hold_receiver(int cycles);
    hold_rx = 1'b1;
    repeat (cycles) @(posedge clk_i);
    hold_rx = 1'b0;
  endtask

  task automatic test_receiver_backpressure();
    fork
      hold_receiver(300);
      begin
        send_random_vector(8);
        send_random_vector(5);
      end
    join
    drain_results();
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    in_ch.last    = 1'b0;
    out_ch.ready  = 1'b0;
    hold_rx       = 1'b0;
    held_dropped  = 1'b0;
    mismatches    = 0;
    stall_cycles  = 0;
    src_idle_pct  = 26;
    sink_idle_pct = 80;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_random_vectors(50);

    src_idle_pct  = 80;
    sink_idle_pct = 26;
    test_store_full();
    test_random_vectors(50);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_receiver_backpressure();
    test_random_vectors(50);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("fractional_rank_with_ties_unit: match");
    end else begin
      $display("fractional_rank_with_ties_unit: mismatch");
    end
    $finish;
  end

endmodule

// ----- fractional_rank_with_ties_unit.f -----
sv/frwt_pkg.sv
sv/frwt_if.sv
sv/frwt_cell.sv
sv/frwt_ctrl.sv
sv/fractional_rank_with_ties_unit.sv
test/tb_fractional_rank_with_ties_unit.sv
